// ----- design/full_search_block_matching_sad_core_macros.svh -----
// Assertion macros shared by the block matching core.
`ifndef FULL_SEARCH_BLOCK_MATCHING_SAD_CORE_MACROS_SVH
`define FULL_SEARCH_BLOCK_MATCHING_SAD_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSBM_ASSERT_IMPL(LBL, CK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CK) disable iff (!RSTN) (ANT) |-> (CON)) \
        else $error(MSG);

// Next-cycle implication, disabled while reset is asserted.
`define FSBM_ASSERT_NEXT(LBL, CK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CK) disable iff (!RSTN) (ANT) |=> (CON)) \
        else $error(MSG);

`endif

// ----- design/fsbm_pkg.sv -----
// Shared types, constants and helpers of the block matching core.
`default_nettype none

package fsbm_pkg;

    // Default sizes
    localparam int MAX_BLOCK_DEF  = 16;
    localparam int MAX_RANGE_DEF  = 16;
    localparam int WINDOW_DIM_DEF = 48;

    // Fixed field widths
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 12;
    localparam int ROWCOL_W   = 6;
    localparam int COST_W     = 16;
    localparam int POS_W      = 14;   // signed frame coordinate with room for -range
    localparam int BS_CFG_W   = 5;
    localparam int SR_CFG_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 40;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_X_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_X_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_Y_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_Y_HIGH = 3'd5;

    // Register reset values
    localparam logic [BS_CFG_W-1:0] BLOCK_SIZE_RST   = 5'd16;
    localparam logic [SR_CFG_W-1:0] SEARCH_RANGE_RST = 5'd7;
    localparam logic [COORD_W-1:0]  BOUND_LOW_RST    = 12'd0;
    localparam logic [COORD_W-1:0]  BOUND_HIGH_RST   = 12'd4095;

    typedef enum logic [1:0] {
        OP_LOAD_CUR = 2'd0,
        OP_LOAD_REF = 2'd1,
        OP_SEARCH   = 2'd2,
        OP_NOP      = 2'd3
    } fsbm_op_t;

    // Per-pixel control riding alongside the memory read data
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic inwin;
    } fsbm_pix_t;

    // Bits needed for a full-block SAD
    function automatic int sad_sum_width(input int max_block);
        return $clog2(max_block * max_block * 255 + 1);
    endfunction

endpackage

`default_nettype wire

// ----- design/fsbm_sad_acc.sv -----
// Absolute-difference accumulator shared by every SAD evaluation.
`default_nettype none

module fsbm_sad_acc #(
    parameter int MAX_BLOCK = fsbm_pkg::MAX_BLOCK_DEF,
    localparam int SUM_W = fsbm_pkg::sad_sum_width(MAX_BLOCK)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire fsbm_pkg::fsbm_pix_t        pix,
    input  wire logic [fsbm_pkg::PIX_W-1:0] ref_pix,
    input  wire logic [fsbm_pkg::PIX_W-1:0] cur_pix,
    output logic                            done,
    output logic [SUM_W-1:0]                sum
);
    import fsbm_pkg::*;

    logic [PIX_W-1:0] ref_eff;
    logic [PIX_W-1:0] diff;
    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] acc_next;
    logic             done_reg;

    // samples outside the window count as zero
    always_comb
    begin
        ref_eff  = pix.inwin ? ref_pix : '0;
        diff     = (ref_eff > cur_pix) ? (ref_eff - cur_pix) : (cur_pix - ref_eff);
        acc_next = (pix.first ? '0 : acc_reg) + SUM_W'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (pix.valid)
            begin
                acc_reg <= acc_next;
            end
            done_reg <= pix.valid && pix.last;
        end
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

`default_nettype wire

// ----- design/full_search_block_matching_sad_core.sv -----
// Top level: full-search block matching motion estimator with SAD cost.
`default_nettype none

// Full-search SAD block matcher. Items arrive on the s_ stream; tuser holds
// the operation. A pixel load (current block or reference window) is one
// transfer with no result. A search transfer runs a scan of the window and
// returns one result transfer on the m_ stream: the absolute best position
// and its SAD (saturated to 16 bits). The window's top-left pixel sits at
// (block_x - range, block_y - range). The SAD at the block's own position is
// taken first; if it is zero, or the clipped window is empty, the answer is
// that position. Otherwise every candidate in the window clipped to the
// bound registers is visited in raster order, and only a strictly smaller
// SAD replaces the best. One shared accumulator reads one current/window
// pixel pair per cycle over each candidate in turn; there are up to
// (2*range + 1)^2 candidates inside the bounds. s_tready is low for the
// whole search. A finished result waits in the output register while pixel
// loads keep flowing. Memory contents are undefined after reset; searching
// over samples never loaded gives an undefined result. Configuration is
// written through cfg_wr_en/cfg_addr/cfg_wdata; the user must do so only
// while no search is running, as the block does not enforce it.

module full_search_block_matching_sad_core #(
    parameter int MAX_BLOCK  = fsbm_pkg::MAX_BLOCK_DEF,
    parameter int MAX_RANGE  = fsbm_pkg::MAX_RANGE_DEF,
    parameter int WINDOW_DIM = fsbm_pkg::WINDOW_DIM_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [fsbm_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [fsbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // row[5:0], col[11:6], pixel[19:12], block_x[31:20], block_y[43:32], zero[47:44]
    input  wire logic [fsbm_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  wire logic [fsbm_pkg::S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // best_x[11:0], best_y[23:12], best_cost[39:24]
    output logic [fsbm_pkg::M_TDATA_W-1:0]       m_tdata
);
    import fsbm_pkg::*;

    `include "full_search_block_matching_sad_core_macros.svh"

    localparam int SUM_W    = sad_sum_width(MAX_BLOCK);
    localparam int EXT_W    = (SUM_W > COST_W) ? SUM_W : COST_W;
    localparam int CUR_DEP  = MAX_BLOCK * MAX_BLOCK;
    localparam int CUR_AW   = (CUR_DEP > 1) ? $clog2(CUR_DEP) : 1;
    localparam int WIN_DEP  = WINDOW_DIM * WINDOW_DIM;
    localparam int WIN_AW   = $clog2(WIN_DEP);
    localparam int BSW      = $clog2(MAX_BLOCK + 1);
    localparam int RW       = $clog2(MAX_RANGE + 1);
    // window row/column counters reach 2*range + block - 1
    localparam int CW       = $clog2(2 * MAX_RANGE + MAX_BLOCK + 1);
    localparam int RB_W     = $clog2((2 * MAX_RANGE + MAX_BLOCK + 1) * WINDOW_DIM + 1);
    localparam int LADDR_W  = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_START,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // ---------------------------------------------------------------
    // Input field unpack
    // ---------------------------------------------------------------
    fsbm_op_t              in_op;
    logic [ROWCOL_W-1:0]   in_row;
    logic [ROWCOL_W-1:0]   in_col;
    logic [PIX_W-1:0]      in_pixel;
    logic [COORD_W-1:0]    in_bx;
    logic [COORD_W-1:0]    in_by;
    logic                  in_fire;

    assign in_op    = fsbm_op_t'(s_tuser[1:0]);
    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[11:6];
    assign in_pixel = s_tdata[19:12];
    assign in_bx    = s_tdata[31:20];
    assign in_by    = s_tdata[43:32];
    assign in_fire  = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t                   state_reg, state_next;
    logic [BS_CFG_W-1:0]      block_size_reg;
    logic [SR_CFG_W-1:0]      search_range_reg;
    logic [COORD_W-1:0]       bound_x_low_reg, bound_x_high_reg;
    logic [COORD_W-1:0]       bound_y_low_reg, bound_y_high_reg;

    logic [COORD_W-1:0]       bx_reg, bx_next, by_reg, by_next;
    logic [BSW-1:0]           bs_reg, bs_next;
    logic [RW-1:0]            r_reg, r_next;
    logic signed [POS_W-1:0]  ox_reg, ox_next, oy_reg, oy_next;
    logic signed [POS_W-1:0]  xlo_reg, xlo_next, xhi_reg, xhi_next;
    logic signed [POS_W-1:0]  ylo_reg, ylo_next, yhi_reg, yhi_next;
    logic signed [POS_W-1:0]  cand_x_reg, cand_x_next, cand_y_reg, cand_y_next;
    logic [CW-1:0]            cand_wx_reg, cand_wx_next, cand_wy_reg, cand_wy_next;
    logic                     center_reg, center_next;
    logic [BSW-1:0]           i_reg, i_next, j_reg, j_next;
    logic [CW-1:0]            wr_reg, wr_next, wc_reg, wc_next;
    logic [RB_W-1:0]          win_row_base_reg, win_row_base_next;
    logic [CUR_AW-1:0]        cur_row_base_reg, cur_row_base_next;
    logic [SUM_W-1:0]         best_reg, best_next;
    logic signed [POS_W-1:0]  best_x_reg, best_x_next, best_y_reg, best_y_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [COORD_W-1:0]       out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [COST_W-1:0]        out_cost_reg, out_cost_next;
    fsbm_pix_t                pix_q_reg;

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    logic [PIX_W-1:0]         cur_mem [CUR_DEP];
    logic [PIX_W-1:0]         win_mem [WIN_DEP];
    logic [PIX_W-1:0]         cur_q_reg;
    logic [PIX_W-1:0]         ref_q_reg;

    logic                     cur_we, win_we;
    logic [LADDR_W-1:0]       cur_waddr_full, win_waddr_full;
    logic [CUR_AW-1:0]        cur_raddr;
    logic [RB_W:0]            win_raddr_full;
    fsbm_pix_t                rd_ctrl;

    // SAD unit
    logic                     sad_done;
    logic [SUM_W-1:0]         sad_sum;

    // scratch
    logic [BSW-1:0]           bsm1;
    logic signed [POS_W-1:0]  ox_c, oy_c, xe_c, ye_c;
    logic signed [POS_W-1:0]  bxl_s, bxh_s, byl_s, byh_s;
    logic [7:0]               bs_cfg_ext, sr_cfg_ext;
    logic [EXT_W-1:0]         best_ext;

    // load addresses: row-major with a constant row pitch
    assign cur_we = in_fire && (in_op == OP_LOAD_CUR)
                    && ({2'b00, in_row} < 8'(MAX_BLOCK))
                    && ({2'b00, in_col} < 8'(MAX_BLOCK));
    assign win_we = in_fire && (in_op == OP_LOAD_REF)
                    && ({2'b00, in_row} < 8'(WINDOW_DIM))
                    && ({2'b00, in_col} < 8'(WINDOW_DIM));
    assign cur_waddr_full = LADDR_W'(in_row) * LADDR_W'(MAX_BLOCK) + LADDR_W'(in_col);
    assign win_waddr_full = LADDR_W'(in_row) * LADDR_W'(WINDOW_DIM) + LADDR_W'(in_col);

    assign cur_raddr      = cur_row_base_reg + CUR_AW'(i_reg);
    assign win_raddr_full = (RB_W + 1)'(win_row_base_reg) + (RB_W + 1)'(wc_reg);

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_waddr_full[CUR_AW-1:0]] <= in_pixel;
        end
        if (rd_ctrl.valid)
        begin
            cur_q_reg <= cur_mem[cur_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[win_waddr_full[WIN_AW-1:0]] <= in_pixel;
        end
        // out-of-window reads are skipped; the SAD unit forces them to zero
        if (rd_ctrl.valid && rd_ctrl.inwin)
        begin
            ref_q_reg <= win_mem[win_raddr_full[WIN_AW-1:0]];
        end
    end

    // ---------------------------------------------------------------
    // Shared SAD accumulator
    // ---------------------------------------------------------------
    fsbm_sad_acc #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_sad (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix_q_reg),
        .ref_pix (ref_q_reg),
        .cur_pix (cur_q_reg),
        .done    (sad_done),
        .sum     (sad_sum)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign bsm1     = bs_reg - 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        bx_next           = bx_reg;
        by_next           = by_reg;
        bs_next           = bs_reg;
        r_next            = r_reg;
        ox_next           = ox_reg;
        oy_next           = oy_reg;
        xlo_next          = xlo_reg;
        xhi_next          = xhi_reg;
        ylo_next          = ylo_reg;
        yhi_next          = yhi_reg;
        cand_x_next       = cand_x_reg;
        cand_y_next       = cand_y_reg;
        cand_wx_next      = cand_wx_reg;
        cand_wy_next      = cand_wy_reg;
        center_next       = center_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        wr_next           = wr_reg;
        wc_next           = wc_reg;
        win_row_base_next = win_row_base_reg;
        cur_row_base_next = cur_row_base_reg;
        best_next         = best_reg;
        best_x_next       = best_x_reg;
        best_y_next       = best_y_reg;
        m_tvalid_next     = m_tvalid_reg;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        out_cost_next     = out_cost_reg;
        rd_ctrl           = '0;

        // clamp configuration into the supported range
        bs_cfg_ext = {3'b000, block_size_reg};
        sr_cfg_ext = {3'b000, search_range_reg};

        // window origin and clipped scan limits
        ox_c  = $signed({2'b00, bx_reg}) - $signed(POS_W'(r_reg));
        oy_c  = $signed({2'b00, by_reg}) - $signed(POS_W'(r_reg));
        xe_c  = $signed({2'b00, bx_reg}) + $signed(POS_W'(r_reg));
        ye_c  = $signed({2'b00, by_reg}) + $signed(POS_W'(r_reg));
        bxl_s = $signed({2'b00, bound_x_low_reg});
        bxh_s = $signed({2'b00, bound_x_high_reg});
        byl_s = $signed({2'b00, bound_y_low_reg});
        byh_s = $signed({2'b00, bound_y_high_reg});

        best_ext = EXT_W'(best_reg);

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_op == OP_SEARCH))
                begin
                    bx_next = in_bx;
                    by_next = in_by;
                    if (bs_cfg_ext == 8'd0)
                    begin
                        bs_next = BSW'(1);
                    end
                    else if (bs_cfg_ext > 8'(MAX_BLOCK))
                    begin
                        bs_next = BSW'(MAX_BLOCK);
                    end
                    else
                    begin
                        bs_next = BSW'(block_size_reg);
                    end
                    r_next = (sr_cfg_ext > 8'(MAX_RANGE)) ? RW'(MAX_RANGE)
                                                          : RW'(search_range_reg);
                    state_next = ST_SETUP;
                end
            end

            ST_SETUP:
            begin
                ox_next      = ox_c;
                oy_next      = oy_c;
                xlo_next     = (ox_c > bxl_s) ? ox_c : bxl_s;
                ylo_next     = (oy_c > byl_s) ? oy_c : byl_s;
                xhi_next     = (xe_c < bxh_s) ? xe_c : bxh_s;
                yhi_next     = (ye_c < byh_s) ? ye_c : byh_s;
                // block's own position first
                cand_wx_next = CW'(r_reg);
                cand_wy_next = CW'(r_reg);
                center_next  = 1'b1;
                best_x_next  = $signed({2'b00, bx_reg});
                best_y_next  = $signed({2'b00, by_reg});
                state_next   = ST_START;
            end

            ST_START:
            begin
                i_next            = '0;
                j_next            = '0;
                wr_next           = cand_wy_reg;
                wc_next           = cand_wx_reg;
                win_row_base_next = RB_W'(cand_wy_reg) * RB_W'(WINDOW_DIM);
                cur_row_base_next = '0;
                state_next        = ST_ISSUE;
            end

            ST_ISSUE:
            begin
                rd_ctrl.valid = 1'b1;
                rd_ctrl.first = (i_reg == '0) && (j_reg == '0);
                rd_ctrl.last  = (i_reg == bsm1) && (j_reg == bsm1);
                rd_ctrl.inwin = ({{(16 - CW){1'b0}}, wr_reg} < 16'(WINDOW_DIM))
                                && ({{(16 - CW){1'b0}}, wc_reg} < 16'(WINDOW_DIM));
                if (i_reg == bsm1)
                begin
                    i_next  = '0;
                    wc_next = cand_wx_reg;
                    if (j_reg == bsm1)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        j_next            = j_reg + 1'b1;
                        wr_next           = wr_reg + 1'b1;
                        win_row_base_next = win_row_base_reg + RB_W'(WINDOW_DIM);
                        cur_row_base_next = cur_row_base_reg + CUR_AW'(MAX_BLOCK);
                    end
                end
                else
                begin
                    i_next  = i_reg + 1'b1;
                    wc_next = wc_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                if (sad_done)
                begin
                    if (center_reg)
                    begin
                        best_next   = sad_sum;
                        center_next = 1'b0;
                        if ((sad_sum == '0) || (xlo_reg > xhi_reg) || (ylo_reg > yhi_reg))
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            cand_x_next  = xlo_reg;
                            cand_y_next  = ylo_reg;
                            cand_wx_next = CW'(xlo_reg - ox_reg);
                            cand_wy_next = CW'(ylo_reg - oy_reg);
                            state_next   = ST_START;
                        end
                    end
                    else
                    begin
                        // strict compare keeps the earliest of equal costs
                        if (sad_sum < best_reg)
                        begin
                            best_next   = sad_sum;
                            best_x_next = cand_x_reg;
                            best_y_next = cand_y_reg;
                        end
                        if (cand_x_reg == xhi_reg)
                        begin
                            if (cand_y_reg == yhi_reg)
                            begin
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                cand_x_next  = xlo_reg;
                                cand_wx_next = CW'(xlo_reg - ox_reg);
                                cand_y_next  = cand_y_reg + 14'sd1;
                                cand_wy_next = cand_wy_reg + 1'b1;
                                state_next   = ST_START;
                            end
                        end
                        else
                        begin
                            cand_x_next  = cand_x_reg + 14'sd1;
                            cand_wx_next = cand_wx_reg + 1'b1;
                            state_next   = ST_START;
                        end
                    end
                end
            end

            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_x_next    = best_x_reg[COORD_W-1:0];
                    out_y_next    = best_y_reg[COORD_W-1:0];
                    out_cost_next = (best_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF
                                                                   : best_ext[COST_W-1:0];
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            block_size_reg   <= BLOCK_SIZE_RST;
            search_range_reg <= SEARCH_RANGE_RST;
            bound_x_low_reg  <= BOUND_LOW_RST;
            bound_x_high_reg <= BOUND_HIGH_RST;
            bound_y_low_reg  <= BOUND_LOW_RST;
            bound_y_high_reg <= BOUND_HIGH_RST;
            bx_reg           <= '0;
            by_reg           <= '0;
            bs_reg           <= '0;
            r_reg            <= '0;
            ox_reg           <= '0;
            oy_reg           <= '0;
            xlo_reg          <= '0;
            xhi_reg          <= '0;
            ylo_reg          <= '0;
            yhi_reg          <= '0;
            cand_x_reg       <= '0;
            cand_y_reg       <= '0;
            cand_wx_reg      <= '0;
            cand_wy_reg      <= '0;
            center_reg       <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            wr_reg           <= '0;
            wc_reg           <= '0;
            win_row_base_reg <= '0;
            cur_row_base_reg <= '0;
            best_reg         <= '0;
            best_x_reg       <= '0;
            best_y_reg       <= '0;
            m_tvalid_reg     <= 1'b0;
            out_x_reg        <= '0;
            out_y_reg        <= '0;
            out_cost_reg     <= '0;
            pix_q_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_BLOCK_SIZE:   block_size_reg   <= cfg_wdata[BS_CFG_W-1:0];
                    CFG_SEARCH_RANGE: search_range_reg <= cfg_wdata[SR_CFG_W-1:0];
                    CFG_BOUND_X_LOW:  bound_x_low_reg  <= cfg_wdata;
                    CFG_BOUND_X_HIGH: bound_x_high_reg <= cfg_wdata;
                    CFG_BOUND_Y_LOW:  bound_y_low_reg  <= cfg_wdata;
                    CFG_BOUND_Y_HIGH: bound_y_high_reg <= cfg_wdata;
                    default:
                    begin
                        // unmapped index, write dropped
                    end
                endcase
            end
            state_reg        <= state_next;
            bx_reg           <= bx_next;
            by_reg           <= by_next;
            bs_reg           <= bs_next;
            r_reg            <= r_next;
            ox_reg           <= ox_next;
            oy_reg           <= oy_next;
            xlo_reg          <= xlo_next;
            xhi_reg          <= xhi_next;
            ylo_reg          <= ylo_next;
            yhi_reg          <= yhi_next;
            cand_x_reg       <= cand_x_next;
            cand_y_reg       <= cand_y_next;
            cand_wx_reg      <= cand_wx_next;
            cand_wy_reg      <= cand_wy_next;
            center_reg       <= center_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            wr_reg           <= wr_next;
            wc_reg           <= wc_next;
            win_row_base_reg <= win_row_base_next;
            cur_row_base_reg <= cur_row_base_next;
            best_reg         <= best_next;
            best_x_reg       <= best_x_next;
            best_y_reg       <= best_y_next;
            m_tvalid_reg     <= m_tvalid_next;
            out_x_reg        <= out_x_next;
            out_y_reg        <= out_y_next;
            out_cost_reg     <= out_cost_next;
            pix_q_reg        <= rd_ctrl;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_cost_reg, out_y_reg, out_x_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `FSBM_ASSERT_IMPL(a_done_in_drain, clk, rst_n, sad_done, state_reg == ST_DRAIN, "SAD done outside drain")
    `FSBM_ASSERT_IMPL(a_pipe_in_scan, clk, rst_n, pix_q_reg.valid, state_reg == ST_ISSUE || state_reg == ST_DRAIN, "pixel in flight outside scan")
    `FSBM_ASSERT_NEXT(a_best_no_rise, clk, rst_n, state_reg == ST_DRAIN && !center_reg, best_reg <= $past(best_reg), "best cost increased")
    `FSBM_ASSERT_IMPL(a_cand_bounds, clk, rst_n, state_reg == ST_ISSUE && !center_reg, cand_x_reg >= xlo_reg && cand_x_reg <= xhi_reg && cand_y_reg >= ylo_reg && cand_y_reg <= yhi_reg, "candidate outside clipped window")

endmodule

`default_nettype wire
